// ===== hdl/rfq_pkg.sv =====
// ----------------------------------------------------------------------------
// rfq_pkg
// shared types and opcodes of the reversible fifo queue
// ----------------------------------------------------------------------------
package rfq_pkg;

  localparam int VALUE_W     = 32;
  localparam int OPCODE_W    = 2;
  localparam int COUNT_OUT_W = 5;

  typedef logic [OPCODE_W-1:0]       opcode_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_OUT_W-1:0]    count_out_t;

  localparam opcode_t OP_ENQUEUE = 2'd0;
  localparam opcode_t OP_DEQUEUE = 2'd1;
  localparam opcode_t OP_REVERSE = 2'd2;

  // pointer updates that take effect at the next clock edge
  typedef struct packed {
    logic enq;
    logic deq;
    logic rev;
  } rfq_upd_t;

endpackage

// ===== hdl/rfq_if.sv =====
// ----------------------------------------------------------------------------
// rfq_in_if / rfq_out_if
// valid/ready channels for queue commands and queue results
// ----------------------------------------------------------------------------
interface rfq_in_if;
  logic              valid;
  logic              ready;
  rfq_pkg::opcode_t  opcode;
  rfq_pkg::value_t   push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface rfq_out_if;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  rfq_pkg::value_t      removed_value;
  logic                 is_empty;
  rfq_pkg::count_out_t  entry_count;

  modport source (output valid, output ok, output removed_value, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input ok, input removed_value, input is_empty,
                  input entry_count, output ready);
endinterface

// ===== hdl/rfq_store.sv =====
// ----------------------------------------------------------------------------
// rfq_store
// ring storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module rfq_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  rfq_pkg::value_t     wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output rfq_pkg::value_t     rdata
);
  import rfq_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rfq_ptr.sv =====
// ----------------------------------------------------------------------------
// rfq_ptr
// front index, fill count and direction bit with ring slot arithmetic
// ----------------------------------------------------------------------------
module rfq_ptr #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rfq_pkg::rfq_upd_t    upd,
  output logic [IDX_W-1:0]     wr_slot,
  output logic [IDX_W-1:0]     rd_slot,
  output logic [CNT_W-1:0]     cnt,
  output logic [CNT_W-1:0]     cnt_next
);
  import rfq_pkg::*;

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W+1)'(DEPTH);

  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic             dir;
  logic [CNT_W-1:0] cnt_dec;

  // slot of logical position pos, pos below DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic d,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    logic [IDX_W:0] diff;
    sum  = {1'b0, f} + {1'b0, pos};
    diff = {1'b0, f} - {1'b0, pos};
    if (d) begin
      if (f < pos) diff = diff + DEPTH_X;
      return diff[IDX_W-1:0];
    end else begin
      if (sum >= DEPTH_X) sum = sum - DEPTH_X;
      return sum[IDX_W-1:0];
    end
  endfunction

  assign cnt_dec = cnt - CNT_W'(1);
  assign rd_slot = front;
  assign wr_slot = slot_of(front, dir, cnt[IDX_W-1:0]);

  always_comb begin
    front_next = front;
    cnt_next   = cnt;
    priority if (upd.deq) begin
      front_next = slot_of(front, dir, IDX_W'(1));
      cnt_next   = cnt_dec;
    end else if (upd.rev) begin
      front_next = slot_of(front, dir, cnt_dec[IDX_W-1:0]);
    end else if (upd.enq) begin
      cnt_next   = cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
      dir   <= 1'b0;
    end else begin
      front <= front_next;
      cnt   <= cnt_next;
      if (upd.rev) dir <= ~dir;
    end
  end

endmodule

// ===== hdl/reversible_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// reversible_fifo_queue
// bounded fifo of signed 32-bit values with enqueue, dequeue and reverse
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | opcode, push_value
//  res     | out | valid / ready | ok, removed_value, is_empty, entry_count
//
//  enqueue, reverse, unused opcodes and a dequeue on an empty queue load the
//  result register on accept; a dequeue that removes a value first passes
//  through ST_DEQ, the registered read of the ring memory
//  one transaction is in flight at a time; cmd.ready waits for the result
//  register to be free or taken in the same cycle
//  rst (synchronous) clears front index, count and direction; the ring
//  memory itself is not cleared, only written slots are ever read
// ----------------------------------------------------------------------------
module reversible_fifo_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  rfq_in_if.sink      cmd,
  rfq_out_if.source   res
);
  import rfq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // controller states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DEQ  = 1'b1;

  logic             state;
  logic             accept;
  logic             full;
  logic             empty;
  logic             ok_imm;
  rfq_upd_t         upd;
  logic [IDX_W-1:0] wr_slot;
  logic [IDX_W-1:0] rd_slot;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  value_t           rdata;

  // result register
  logic             res_valid;
  logic             res_ok;
  value_t           res_removed;
  logic             res_empty;
  count_out_t       res_count;

  assign full  = (cnt == DEPTH_C);
  assign empty = (cnt == '0);

  // new transaction only when idle and the result slot frees up
  assign cmd.ready = (state == ST_IDLE) && (!res_valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;

  // pointer updates, only for operations that change the queue
  assign upd.enq = accept && (cmd.opcode == OP_ENQUEUE) && !full;
  assign upd.deq = accept && (cmd.opcode == OP_DEQUEUE) && !empty;
  assign upd.rev = accept && (cmd.opcode == OP_REVERSE) && (cnt > CNT_W'(1));

  // status of everything answered in the accept cycle
  always_comb begin
    unique case (cmd.opcode)
      OP_ENQUEUE: ok_imm = !full;
      OP_DEQUEUE: ok_imm = 1'b0;   // only an empty dequeue answers here
      OP_REVERSE: ok_imm = 1'b1;
      default:    ok_imm = 1'b0;
    endcase
  end

  rfq_ptr #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ptr (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .wr_slot  (wr_slot),
    .rd_slot  (rd_slot),
    .cnt      (cnt),
    .cnt_next (cnt_next)
  );

  // front slot is read on every cycle; the value is used after a dequeue accept
  rfq_store #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (upd.enq),
    .waddr (wr_slot),
    .wdata (cmd.push_value),
    .raddr (rd_slot),
    .rdata (rdata)
  );

  // control: state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (upd.deq) state <= ST_DEQ;
            else         res_valid <= 1'b1;
          end
        end
        ST_DEQ: begin
          state     <= ST_IDLE;
          res_valid <= 1'b1;
        end
      endcase
    end
  end

  // result payload; after a dequeue the pointers already hold the new count
  always_ff @(posedge clk) begin
    if (accept && !upd.deq) begin
      res_ok      <= ok_imm;
      res_removed <= '0;
      res_empty   <= (cnt_next == '0);
      res_count   <= COUNT_OUT_W'(cnt_next);
    end else if (state == ST_DEQ) begin
      res_ok      <= 1'b1;
      res_removed <= rdata;
      res_empty   <= empty;
      res_count   <= COUNT_OUT_W'(cnt);
    end
  end

  assign res.valid         = res_valid;
  assign res.ok            = res_ok;
  assign res.removed_value = res_removed;
  assign res.is_empty      = res_empty;
  assign res.entry_count   = res_count;

`ifndef SYNTHESIS
  // count never passes the ring depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= DEPTH_C)
    else $error("queue count above depth");

  // a pending dequeue always delivers its result next cycle
  a_deq_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEQ |=> res_valid && state == ST_IDLE)
    else $error("dequeue result not delivered");

  // no new transaction while a dequeue read is outstanding
  a_no_accept_deq: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEQ |-> !cmd.ready)
    else $error("transaction accepted during dequeue read");

  // a failed result never carries a removed value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ok |-> res_removed == '0)
    else $error("failed result with nonzero value");
`endif

endmodule
